// ===== hdl/vertex_matrix_transform_core_macros.svh =====
// assertion macros used by the checker file
`ifndef VERTEX_MATRIX_TRANSFORM_CORE_MACROS_SVH
`define VERTEX_MATRIX_TRANSFORM_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define VMT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vmt check failed: same-cycle rule");

// next-cycle implication, disabled during reset
`define VMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vmt check failed: next-cycle rule");

`endif

// ===== hdl/vmt_pkg.sv =====
package vmt_pkg;

  // field widths
  localparam int COMP_W          = 32;
  localparam int COEFF_W         = 16;
  localparam int NUM_COMP        = 4;
  localparam int ROW_W           = COEFF_W * NUM_COMP;
  localparam int TDATA_W         = COMP_W * NUM_COMP;
  localparam int ROWS_W          = 3;

  // default coefficient fraction bits
  localparam int COEFF_FRAC_BITS = 8;

  // arithmetic widths: product, pair sum, full sum
  localparam int PROD_W          = COMP_W + COEFF_W;
  localparam int PAIR_W          = PROD_W + 1;
  localparam int SUM_W           = PROD_W + 2;

  // configuration port
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = ROW_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 3'd4;

  localparam logic [ROWS_W-1:0] ROWS_RESET = 3'd4;

  typedef logic signed [COMP_W-1:0]  comp_t;
  typedef logic signed [COEFF_W-1:0] coeff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [PAIR_W-1:0]  pair_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

endpackage

// ===== hdl/vertex_matrix_transform_core.sv =====
// Transforms one homogeneous Q16.16 point per request by a 4x4 matrix of Q8.8
// coefficients (point as row vector, only the first rows_in_use rows summed),
// shifts each sum right by the fraction bits and clamps it to 32 bits. The
// block takes one point every clock unless out_tready holds the output. Four
// register stages (multiply, pair add, final add, shift and clamp) follow; the
// first stage loads on the edge that accepts the point, the result shows on
// the output once the last stage loads. Back-pressure from out_tready travels
// up the stages, empty stages fill while the output waits. Configuration writes
// are taken at any time but should only happen while no point is in flight.
module vertex_matrix_transform_core #(
  parameter int COEFF_FRAC_BITS = vmt_pkg::COEFF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [vmt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vmt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // point requests
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [vmt_pkg::TDATA_W-1:0]    in_tdata,   // in_x, in_y, in_z, in_w
  input  logic                           in_tlast,   // last_point
  // result requests
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [vmt_pkg::TDATA_W-1:0]    out_tdata,  // out_x, out_y, out_z, out_w
  output logic                           out_tuser,  // saturated
  output logic                           out_tlast   // last_out
);

  localparam int NC      = vmt_pkg::NUM_COMP;
  localparam int CW      = vmt_pkg::COMP_W;
  localparam int KW      = vmt_pkg::COEFF_W;
  localparam int SHIFT_W = vmt_pkg::SUM_W - COEFF_FRAC_BITS;
  localparam int UPPER_W = SHIFT_W - CW + 1;

  // configuration registers
  logic [vmt_pkg::ROW_W-1:0]  coeff_r [NC];
  logic [vmt_pkg::ROWS_W-1:0] rows_r;

  // pipeline registers
  logic                 v1_r, v2_r, v3_r, v4_r;
  logic                 last1_r, last2_r, last3_r, last4_r;
  vmt_pkg::prod_t       prod_r [NC][NC];   // [output comp][row]
  vmt_pkg::pair_t       pair_r [NC][2];
  vmt_pkg::sum_t        sum_r  [NC];
  logic [CW-1:0]        res_r  [NC];
  logic                 sat_r;

  vmt_pkg::prod_t       prod_nxt [NC][NC];
  vmt_pkg::pair_t       pair_nxt [NC][2];
  vmt_pkg::sum_t        sum_nxt  [NC];
  logic [CW-1:0]        res_nxt  [NC];
  logic                 sat_nxt;

  logic                 rdy1, rdy2, rdy3, rdy4;

  // stage ready chain, a stage moves when empty or when the next one moves
  assign rdy4      = !v4_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NC; j++) begin
        coeff_r[j] <= '0;
      end
      rows_r <= vmt_pkg::ROWS_RESET;
    end else if (cfg_we) begin
      if (cfg_index inside {vmt_pkg::CFG_ROW0, vmt_pkg::CFG_ROW1,
                            vmt_pkg::CFG_ROW2, vmt_pkg::CFG_ROW3}) begin
        coeff_r[cfg_index[1:0]] <= cfg_wdata;
      end else if (cfg_index == vmt_pkg::CFG_ROWS) begin
        rows_r <= cfg_wdata[vmt_pkg::ROWS_W-1:0];
      end
    end
  end

  // stage 1: products, rows past the row count use a zero coefficient
  always_comb begin
    vmt_pkg::comp_t  p;
    vmt_pkg::coeff_t c;
    for (int i = 0; i < NC; i++) begin
      for (int j = 0; j < NC; j++) begin
        p = vmt_pkg::comp_t'(in_tdata[j*CW +: CW]);
        c = (vmt_pkg::ROWS_W'(j) < rows_r) ? vmt_pkg::coeff_t'(coeff_r[j][i*KW +: KW])
                                           : '0;
        prod_nxt[i][j] = vmt_pkg::prod_t'(p) * vmt_pkg::prod_t'(c);
      end
    end
  end

  // stage 2: pair sums
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      pair_nxt[i][0] = vmt_pkg::pair_t'(prod_r[i][0]) + vmt_pkg::pair_t'(prod_r[i][1]);
      pair_nxt[i][1] = vmt_pkg::pair_t'(prod_r[i][2]) + vmt_pkg::pair_t'(prod_r[i][3]);
    end
  end

  // stage 3: full sums
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      sum_nxt[i] = vmt_pkg::sum_t'(pair_r[i][0]) + vmt_pkg::sum_t'(pair_r[i][1]);
    end
  end

  // stage 4: floor shift by the fraction bits, then clamp to 32 bits
  always_comb begin
    logic [SHIFT_W-1:0] shifted;
    logic [UPPER_W-1:0] upper;
    logic               sign;
    sat_nxt = 1'b0;
    for (int i = 0; i < NC; i++) begin
      shifted = sum_r[i][vmt_pkg::SUM_W-1:COEFF_FRAC_BITS];
      upper   = shifted[SHIFT_W-1:CW-1];
      sign    = shifted[SHIFT_W-1];
      if ((&upper) || !(|upper)) begin
        res_nxt[i] = shifted[CW-1:0];
      end else begin
        res_nxt[i] = {sign, {(CW-1){!sign}}};
        sat_nxt    = 1'b1;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && rdy1) begin
      prod_r  <= prod_nxt;
      last1_r <= in_tlast;
    end
    if (v1_r && rdy2) begin
      pair_r  <= pair_nxt;
      last2_r <= last1_r;
    end
    if (v2_r && rdy3) begin
      sum_r   <= sum_nxt;
      last3_r <= last2_r;
    end
    if (v3_r && rdy4) begin
      res_r   <= res_nxt;
      sat_r   <= sat_nxt;
      last4_r <= last3_r;
    end
  end

  // result port
  assign out_tvalid = v4_r;
  assign out_tdata  = {res_r[3], res_r[2], res_r[1], res_r[0]};
  assign out_tuser  = sat_r;
  assign out_tlast  = last4_r;

endmodule

// ===== hdl/vmt_checker.sv =====
`include "vertex_matrix_transform_core_macros.svh"

module vmt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [vmt_pkg::TDATA_W-1:0] out_tdata,
  input logic                        out_tuser,
  input logic                        out_tlast
);

  localparam int CW = vmt_pkg::COMP_W;

  logic [CW-1:0] pos_max;
  logic [CW-1:0] neg_min;
  logic          any_clamp_value;
  logic          stalled;

  assign pos_max = {1'b0, {(CW-1){1'b1}}};
  assign neg_min = {1'b1, {(CW-1){1'b0}}};

  // a flagged result must carry at least one clamped component
  assign any_clamp_value =
    (out_tdata[0*CW +: CW] == pos_max) || (out_tdata[0*CW +: CW] == neg_min) ||
    (out_tdata[1*CW +: CW] == pos_max) || (out_tdata[1*CW +: CW] == neg_min) ||
    (out_tdata[2*CW +: CW] == pos_max) || (out_tdata[2*CW +: CW] == neg_min) ||
    (out_tdata[3*CW +: CW] == pos_max) || (out_tdata[3*CW +: CW] == neg_min);

  assign stalled = out_tvalid && !out_tready;

  // saturation flag matches the data
  `VMT_ASSERT_NOW(a_sat_has_clamp, clk, rst_n, out_tvalid && out_tuser, any_clamp_value)

  // a free output lets the whole pipeline take a point
  `VMT_ASSERT_NOW(a_ready_when_drained, clk, rst_n, out_tready, in_tready)

  // a stalled result holds
  `VMT_ASSERT_NEXT(a_out_hold, clk, rst_n, stalled, out_tvalid && $stable({out_tdata, out_tuser, out_tlast}))

endmodule

bind vertex_matrix_transform_core vmt_checker u_vmt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== tb/sv/vertex_matrix_transform_core_tb.sv =====
module vertex_matrix_transform_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int      STALL_LIMIT = 1000;
  localparam int      SETTLE_CYCLES = 12;
  localparam int      NUM_COMP = vmt_pkg::NUM_COMP;
  localparam int      COMP_W = vmt_pkg::COMP_W;
  localparam int      COEFF_W = vmt_pkg::COEFF_W;
  localparam int      ROW_W = vmt_pkg::ROW_W;
  localparam int      ROWS_W = vmt_pkg::ROWS_W;
  localparam int      TDATA_W = vmt_pkg::TDATA_W;
  localparam int      CFG_IDX_W = vmt_pkg::CFG_IDX_W;
  localparam int      CFG_DATA_W = vmt_pkg::CFG_DATA_W;
  localparam int      COEFF_FRAC_BITS = vmt_pkg::COEFF_FRAC_BITS;
  localparam longint  SUM_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint  SUM_MIN = -64'sh0000_0000_8000_0000;
  localparam vmt_pkg::comp_t  COMP_MAX = 32'sh7FFF_FFFF;
  localparam vmt_pkg::comp_t  COMP_MIN = 32'sh8000_0000;
  localparam vmt_pkg::coeff_t COEFF_MAX = 16'sh7FFF;
  localparam vmt_pkg::coeff_t COEFF_MIN = 16'sh8000;
  localparam vmt_pkg::coeff_t COEFF_ONE = vmt_pkg::coeff_t'(1 << COEFF_FRAC_BITS);
  localparam vmt_pkg::comp_t  COMP_ONE = 32'sh0001_0000;

  typedef struct packed {
    logic [TDATA_W-1:0] data;
    logic               last;
  } vertex_t;

  typedef struct packed {
    logic [TDATA_W-1:0] data;
    logic               sat;
    logic               last;
  } vertex_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [TDATA_W-1:0]    in_tdata = '0;   // in_x, in_y, in_z, in_w
  logic                  in_tlast = 1'b0; // last_point
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [TDATA_W-1:0]    out_tdata;       // out_x, out_y, out_z, out_w
  logic                  out_tuser;       // saturated
  logic                  out_tlast;       // last_out

  vertex_matrix_transform_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // matrix copy used for prediction
  logic [ROW_W-1:0]  coeff_rows [NUM_COMP];
  logic [ROWS_W-1:0] rows_cfg;

  vertex_t        pending_points [$];
  vertex_result_t predicted_results [$];

  int    in_idle_pct = 0;
  int    out_stall_pct = 0;
  int    points_queued = 0;
  int    points_taken = 0;
  int    results_checked = 0;
  int    clamped_seen = 0;
  int    settings_used = 0;
  int    error_count = 0;
  int    quiet_cycles = 0;
  logic  in_taken = 1'b0;
  string comp_name [NUM_COMP] = '{"x", "y", "z", "w"};

  initial begin
    forever #5 clk = ~clk;
  end

  // point times matrix, floor shift, clamp to 32 bits
  function automatic vertex_result_t transform_point(logic [TDATA_W-1:0] data, logic last);
    vertex_result_t  res;
    longint          acc;
    longint          val;
    vmt_pkg::comp_t  p;
    vmt_pkg::coeff_t c;
    int              n_rows;
    n_rows = (rows_cfg > NUM_COMP) ? NUM_COMP : int'(rows_cfg);
    res.sat = 1'b0;
    res.last = last;
    res.data = '0;
    for (int i = 0; i < NUM_COMP; i++) begin
      acc = 0;
      for (int j = 0; j < n_rows; j++) begin
        p = data[COMP_W*j +: COMP_W];
        c = coeff_rows[j][COEFF_W*i +: COEFF_W];
        acc += longint'(p) * longint'(c);
      end
      val = acc >>> COEFF_FRAC_BITS;
      if (val > SUM_MAX) begin
        val = SUM_MAX;
        res.sat = 1'b1;
      end else if (val < SUM_MIN) begin
        val = SUM_MIN;
        res.sat = 1'b1;
      end
      res.data[COMP_W*i +: COMP_W] = val[COMP_W-1:0];
    end
    return res;
  endfunction

  // mix of extremes, full range and shrunk magnitudes
  function automatic vmt_pkg::comp_t random_comp();
    vmt_pkg::comp_t v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0: v = COMP_MAX;
      1: v = COMP_MIN;
      2, 3: ;
      default: v = v >>> $urandom_range(0, 31);
    endcase
    return v;
  endfunction

  function automatic logic [ROW_W-1:0] random_row(bit narrow);
    logic [ROW_W-1:0] row;
    int               v;
    row = {$urandom, $urandom};
    if (narrow) begin
      for (int i = 0; i < NUM_COMP; i++) begin
        v = $urandom_range(0, 1024) - 512;
        row[COEFF_W*i +: COEFF_W] = v[COEFF_W-1:0];
      end
    end
    return row;
  endfunction

  // register write, also updates the predictor copy
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      vmt_pkg::CFG_ROW0, vmt_pkg::CFG_ROW1,
      vmt_pkg::CFG_ROW2, vmt_pkg::CFG_ROW3: coeff_rows[idx[1:0]] = data;
      vmt_pkg::CFG_ROWS: rows_cfg = data[ROWS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_matrix(logic [ROW_W-1:0] r0, logic [ROW_W-1:0] r1,
                            logic [ROW_W-1:0] r2, logic [ROW_W-1:0] r3,
                            logic [ROWS_W-1:0] rows);
    write_reg(vmt_pkg::CFG_ROW0, r0);
    write_reg(vmt_pkg::CFG_ROW1, r1);
    write_reg(vmt_pkg::CFG_ROW2, r2);
    write_reg(vmt_pkg::CFG_ROW3, r3);
    write_reg(vmt_pkg::CFG_ROWS, CFG_DATA_W'(rows));
    settings_used++;
  endtask

  task automatic send_point(vmt_pkg::comp_t x, vmt_pkg::comp_t y, vmt_pkg::comp_t z,
                            vmt_pkg::comp_t w, logic last);
    vertex_t pt;
    pt.data = {w, z, y, x};
    pt.last = last;
    pending_points = {pending_points, pt};
    points_queued++;
  endtask

  task automatic send_random_point();
    send_point(random_comp(), random_comp(), random_comp(), random_comp(),
               $urandom_range(0, 7) == 0);
  endtask

  // wait until every point is taken and every result has come back
  task automatic drain();
    while (points_taken != points_queued || predicted_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_idle(int mode);
    case (mode)
      0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1: begin in_idle_pct = 49; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 49; end
      default: begin in_idle_pct = 21; out_stall_pct = 21; end
    endcase
  endtask

  // point driver
  always @(negedge clk) begin
    vertex_t pt;
    logic    next_valid;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else if (in_tvalid && !in_taken) begin
      next_valid = 1'b1;
    end else if (pending_points.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
      pt = pending_points.pop_front();
      in_tdata <= pt.data;
      in_tlast <= pt.last;
      next_valid = 1'b1;
    end else begin
      next_valid = 1'b0;
    end
    in_tvalid <= next_valid;
    out_tready <= rst_n && ($urandom_range(0, 99) >= out_stall_pct);
  end

  // predict on every accepted point request
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      predicted_results = {predicted_results, transform_point(in_tdata, in_tlast)};
      points_taken++;
    end
  end

  // result monitor
  always @(posedge clk) begin
    vertex_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (predicted_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result data=%h sat=%b last=%b",
                 $time, out_tdata, out_tuser, out_tlast);
      end else begin
        want = predicted_results.pop_front();
        results_checked++;
        if (out_tuser) clamped_seen++;
        for (int i = 0; i < NUM_COMP; i++) begin
          if (out_tdata[COMP_W*i +: COMP_W] !== want.data[COMP_W*i +: COMP_W]) begin
            error_count++;
            $display("%0t: out_%s expected %h actual %h", $time, comp_name[i],
                     want.data[COMP_W*i +: COMP_W], out_tdata[COMP_W*i +: COMP_W]);
          end
        end
        if (out_tuser !== want.sat) begin
          error_count++;
          $display("%0t: saturated expected %b actual %b", $time, want.sat, out_tuser);
        end
        if (out_tlast !== want.last) begin
          error_count++;
          $display("%0t: last_out expected %b actual %b", $time, want.last, out_tlast);
        end
      end
    end
  end

  // watchdog on cycles without any request moving
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
      $display("vertex_matrix_transform_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [ROWS_W-1:0] rows;
    bit                narrow;
    for (int j = 0; j < NUM_COMP; j++) coeff_rows[j] = '0;
    rows_cfg = vmt_pkg::ROWS_RESET;

    // reset
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_idle(0);

    // reset matrix is all zero
    settings_used++;
    send_point(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, 1'b0);
    send_point(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, 1'b1);
    drain();

    // identity matrix passes points through
    set_matrix(ROW_W'(COEFF_ONE), ROW_W'(COEFF_ONE) << COEFF_W,
               ROW_W'(COEFF_ONE) << (2 * COEFF_W), ROW_W'(COEFF_ONE) << (3 * COEFF_W),
               ROWS_W'(NUM_COMP));
    send_point('0, '0, '0, '0, 1'b0);
    send_point(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, 1'b0);
    send_point(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, 1'b0);
    send_point(32'sd1, -32'sd1, 32'sh1234_5678, 32'sh8000_0001, 1'b0);
    send_point(-32'sd1, '0, COMP_MAX, -32'sd2, 1'b1);
    drain();

    // largest positive coefficients, clamp both ways
    set_matrix({NUM_COMP{COEFF_MAX}}, {NUM_COMP{COEFF_MAX}}, {NUM_COMP{COEFF_MAX}},
               {NUM_COMP{COEFF_MAX}}, ROWS_W'(NUM_COMP));
    send_point(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, 1'b0);
    send_point(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, 1'b0);
    send_point(COMP_ONE, COMP_ONE, COMP_ONE, COMP_ONE, 1'b1);
    drain();

    // most negative coefficients
    set_matrix({NUM_COMP{COEFF_MIN}}, {NUM_COMP{COEFF_MIN}}, {NUM_COMP{COEFF_MIN}},
               {NUM_COMP{COEFF_MIN}}, ROWS_W'(NUM_COMP));
    send_point(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, 1'b0);
    send_point(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, 1'b0);
    send_point(-32'sd1, -32'sd1, -32'sd1, -32'sd1, 1'b1);
    drain();

    // no rows in use gives zero without clamp
    set_matrix(random_row(0), random_row(0), random_row(0), random_row(0), '0);
    send_point(COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN, 1'b0);
    send_random_point();
    drain();

    // partial row counts and counts above four
    for (int r = 1; r < (1 << ROWS_W); r++) begin
      if (r == NUM_COMP) continue;
      set_matrix(random_row(1), random_row(1), random_row(1), random_row(1), ROWS_W'(r));
      send_random_point();
      drain();
    end

    // unused register indexes must not disturb the matrix
    for (int k = int'(vmt_pkg::CFG_ROWS) + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), {$urandom, $urandom});

    // random matrices and points under every idle mix
    for (int ph = 0; ph < 12; ph++) begin
      narrow = $urandom_range(0, 2) != 0;
      rows = $urandom_range(0, 1) ? ROWS_W'(NUM_COMP) : ROWS_W'($urandom_range(0, 7));
      set_matrix(random_row(narrow), random_row(narrow), random_row(narrow),
                 random_row(narrow), rows);
      set_idle(ph % 4);
      for (int n = 0; n < 40; n++) send_random_point();
      drain();
    end

    // end of run
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("%0d points and %0d results checked over %0d matrix settings, %0d clamped",
             points_taken, results_checked, settings_used, clamped_seen);
    $display("row counts 0 to 7, extreme coefficients and points, gaps and stalls on both sides");
    if (error_count == 0) begin
      $display("vertex_matrix_transform_core: match");
    end else begin
      $display("vertex_matrix_transform_core: mismatch");
    end
    $finish;
  end

endmodule
